/* rtl/core/assert_macros.svh */
// assertion macros of the terminal cursor engine rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define VTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// condition must never be true
`define VTC_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

/* rtl/core/vtc_pkg.sv */
// types, codes and constants of the terminal cursor engine
// no dependencies
package vtc_pkg;

   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 128;
   localparam int MAX_PARAMS = 16;
   localparam int ROW_W      = 6;
   localparam int COL_W      = 7;
   localparam int IDX_W      = $clog2(MAX_PARAMS);
   localparam int CNT_W      = $clog2(MAX_PARAMS + 1);
   localparam int PARAM_W    = 16;
   localparam int TDATA_W    = 48;

   localparam logic [1:0] OP_CELL   = 2'd0;
   localparam logic [1:0] OP_SCROLL = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   localparam logic [7:0] CH_BEL   = 8'h07;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_ESC   = 8'h1b;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SEMI  = 8'h3b;
   localparam logic [7:0] CH_QUEST = 8'h3f;
   localparam logic [7:0] CH_LBRK  = 8'h5b;
   localparam logic [7:0] CH_RBRK  = 8'h5d;
   localparam logic [7:0] CMD_CUP  = 8'h48;
   localparam logic [7:0] CMD_HVP  = 8'h66;
   localparam logic [7:0] CMD_CUU  = 8'h41;
   localparam logic [7:0] CMD_CUD  = 8'h42;
   localparam logic [7:0] CMD_CUF  = 8'h43;
   localparam logic [7:0] CMD_CUB  = 8'h44;
   localparam logic [7:0] CMD_ED   = 8'h4a;
   localparam logic [7:0] CMD_EL   = 8'h4b;
   localparam logic [7:0] CMD_SGR  = 8'h6d;

   localparam logic [3:0] FG_RESET = 4'd7;

   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_ESCAPE,
      MODE_CSI,
      MODE_OSC
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SGR_RD,
      ST_SGR_AP,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic sgr_apply;
      logic load_second;
   } cmd_type;

   typedef struct packed {
      logic has_result;
      logic has_second;
      logic sgr_start;
      logic sgr_last;
   } status_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] end_row;
      logic [COL_W-1:0] end_col;
      logic [6:0]       glyph;
      logic [3:0]       fg_color;
      logic [3:0]       bg_color;
      logic [2:0]       style;
      logic             last;
   } res_type;

endpackage

/* rtl/core/vtc_ram.sv */
// generic single write, single read ram with registered read
// no dependencies
module vtc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/vtc_ctrl.sv */
// controller state machine of the terminal cursor engine
// depends on vtc_pkg and assert_macros.svh
`include "assert_macros.svh"
module vtc_ctrl
   import vtc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.sgr_start) state_in = ST_SGR_RD;
            else if (status.has_result) state_in = ST_SEND;
            else state_in = ST_IDLE;
         end
         ST_SGR_RD: state_in = ST_SGR_AP;
         ST_SGR_AP: begin
            if (status.sgr_last) state_in = ST_IDLE;
            else state_in = ST_SGR_RD;
         end
         ST_SEND: begin
            if (rsp_tready && !status.has_second) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready      = 1'b0;
      rsp_tvalid      = 1'b0;
      cmd             = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_EXEC:   cmd.exec = 1'b1;
         ST_SGR_RD: cmd = '0;
         ST_SGR_AP: cmd.sgr_apply = 1'b1;
         ST_SEND: begin
            rsp_tvalid      = 1'b1;
            cmd.load_second = rsp_tready && status.has_second;
         end
         default: cmd = '0;
      endcase
   end

   `VTC_ASSERT_NEVER(a_one_side, clock, reset, req_tready && rsp_tvalid, "both sides open")
   `VTC_ASSERT_NEXT(a_exec_after_accept, clock, reset, req_tvalid && req_tready,
      state_ff == ST_EXEC, "accepted item not executed")
   `VTC_ASSERT_NEXT(a_hold_result, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid, "result dropped while stalled")

endmodule

/* rtl/core/vtc_dp.sv */
// datapath: parser mode, parameters, cursor, attributes and result register
// depends on vtc_pkg and vtc_ram
module vtc_dp
   import vtc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_addr,
   input  logic [7:0] csr_wdata,
   input  logic [7:0] req_byte,
   input  cmd_type    cmd,
   output status_type status,
   output res_type    result
);

   logic [6:0]         screen_rows_ff;
   logic [7:0]         screen_cols_ff;
   logic [7:0]         byte_ff;
   mode_type           mode_ff, mode_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               open_ff, open_in;
   logic               kept_ff, kept_in;
   logic [PARAM_W-1:0] acc_ff, acc_in;
   logic [PARAM_W-1:0] p0_ff, p0_in;
   logic [PARAM_W-1:0] p1_ff, p1_in;
   logic [ROW_W-1:0]   crow_ff, crow_in;
   logic [COL_W-1:0]   ccol_ff, ccol_in;
   logic [3:0]         fg_ff, fg_in;
   logic [3:0]         bg_ff, bg_in;
   logic [2:0]         style_ff, style_in;
   logic [IDX_W-1:0]   sgr_idx_ff, sgr_idx_in;
   res_type            out_ff, out_in;
   logic               second_ff, second_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [PARAM_W-1:0] wr_data;
   logic [PARAM_W-1:0] rd_data;

   logic [ROW_W-1:0]   rows_m1, cr;
   logic [COL_W-1:0]   cols_m1, cc;
   logic [PARAM_W-1:0] base, step, p0m1, p1m1;
   logic [19:0]        prod;
   logic [7:0]         tab;
   logic [16:0]        row_sum, col_sum;
   logic               is_digit;
   res_type            cell_res, clear_res, scroll_res;

   vtc_ram #(.WIDTH(PARAM_W), .DEPTH(MAX_PARAMS)) u_params (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(sgr_idx_ff),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_rows_ff <= 7'd24;
         screen_cols_ff <= 8'd80;
         mode_ff        <= MODE_NORMAL;
         count_ff       <= '0;
         open_ff        <= 1'b0;
         kept_ff        <= 1'b0;
         p0_ff          <= '0;
         p1_ff          <= '0;
         crow_ff        <= '0;
         ccol_ff        <= '0;
         fg_ff          <= FG_RESET;
         bg_ff          <= '0;
         style_ff       <= '0;
         second_ff      <= 1'b0;
      end else begin
         if (csr_we && csr_addr == CSR_ROWS) screen_rows_ff <= csr_wdata[6:0];
         if (csr_we && csr_addr == CSR_COLS) screen_cols_ff <= csr_wdata;
         mode_ff   <= mode_in;
         count_ff  <= count_in;
         open_ff   <= open_in;
         kept_ff   <= kept_in;
         p0_ff     <= p0_in;
         p1_ff     <= p1_in;
         crow_ff   <= crow_in;
         ccol_ff   <= ccol_in;
         fg_ff     <= fg_in;
         bg_ff     <= bg_in;
         style_ff  <= style_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) byte_ff <= req_byte;
      acc_ff     <= acc_in;
      sgr_idx_ff <= sgr_idx_in;
      out_ff     <= out_in;
   end

   always_comb begin
      rows_m1 = (screen_rows_ff == 7'd0) ? '0 :
                (screen_rows_ff > 7'(MAX_ROWS)) ? ROW_W'(MAX_ROWS - 1) :
                ROW_W'(screen_rows_ff - 7'd1);
      cols_m1 = (screen_cols_ff == 8'd0) ? '0 :
                (screen_cols_ff > 8'(MAX_COLS)) ? COL_W'(MAX_COLS - 1) :
                COL_W'(screen_cols_ff - 8'd1);
      cr = (crow_ff > rows_m1) ? rows_m1 : crow_ff;
      cc = (ccol_ff > cols_m1) ? cols_m1 : ccol_ff;
      is_digit = byte_ff >= 8'h30 && byte_ff <= 8'h39;
      base = open_ff ? acc_ff : '0;
      prod = {4'd0, base} * 20'd10 + {16'd0, byte_ff[3:0]};
      step = (p0_ff == '0) ? PARAM_W'(1) : p0_ff;
      p0m1 = (p0_ff == '0) ? '0 : p0_ff - PARAM_W'(1);
      p1m1 = (p1_ff == '0) ? '0 : p1_ff - PARAM_W'(1);
      tab = ({1'b0, cc} + 8'd8) & 8'hf8;
      row_sum = {11'd0, cr} + {1'b0, step};
      col_sum = {10'd0, cc} + {1'b0, step};

      cell_res = '{op: OP_CELL, row: cr, col: cc, end_row: cr, end_col: cc,
                   glyph: byte_ff[6:0], fg_color: fg_ff, bg_color: bg_ff,
                   style: style_ff, last: 1'b1};
      clear_res = '{op: OP_CLEAR, row: cr, col: cc, end_row: rows_m1, end_col: cols_m1,
                    glyph: CH_SPACE[6:0], fg_color: fg_ff, bg_color: bg_ff,
                    style: style_ff, last: 1'b1};
      scroll_res = '0;
      scroll_res.op   = OP_SCROLL;
      scroll_res.last = 1'b1;
   end

   always_comb begin
      mode_in    = mode_ff;
      count_in   = count_ff;
      open_in    = open_ff;
      kept_in    = kept_ff;
      acc_in     = acc_ff;
      p0_in      = p0_ff;
      p1_in      = p1_ff;
      crow_in    = crow_ff;
      ccol_in    = ccol_ff;
      fg_in      = fg_ff;
      bg_in      = bg_ff;
      style_in   = style_ff;
      sgr_idx_in = sgr_idx_ff;
      out_in     = out_ff;
      second_in  = second_ff;
      wr_en      = 1'b0;
      wr_addr    = count_ff[IDX_W-1:0];
      wr_data    = '0;
      status     = '0;

      if (cmd.exec) begin
         crow_in   = cr;
         ccol_in   = cc;
         second_in = 1'b0;
         if (!byte_ff[7]) begin
            case (mode_ff)
               MODE_NORMAL: begin
                  if (byte_ff == CH_ESC) begin
                     mode_in = MODE_ESCAPE;
                  end else if (byte_ff == CH_CR) begin
                     ccol_in = '0;
                  end else if (byte_ff == CH_LF) begin
                     if (cr == rows_m1) begin
                        out_in            = scroll_res;
                        status.has_result = 1'b1;
                     end else begin
                        crow_in = cr + ROW_W'(1);
                     end
                  end else if (byte_ff == CH_BS) begin
                     if (cc != '0) ccol_in = cc - COL_W'(1);
                  end else if (byte_ff == CH_TAB) begin
                     ccol_in = (tab > {1'b0, cols_m1}) ? cols_m1 : tab[COL_W-1:0];
                  end else if (byte_ff >= CH_SPACE) begin
                     out_in            = cell_res;
                     status.has_result = 1'b1;
                     if (cc == cols_m1) begin
                        ccol_in = '0;
                        if (cr == rows_m1) begin
                           out_in.last = 1'b0;
                           second_in   = 1'b1;
                        end else begin
                           crow_in = cr + ROW_W'(1);
                        end
                     end else begin
                        ccol_in = cc + COL_W'(1);
                     end
                  end
               end
               MODE_ESCAPE: begin
                  if (byte_ff == CH_LBRK) begin
                     mode_in  = MODE_CSI;
                     count_in = '0;
                     open_in  = 1'b0;
                     kept_in  = 1'b0;
                     p0_in    = '0;
                     p1_in    = '0;
                  end else if (byte_ff == CH_RBRK) begin
                     mode_in = MODE_OSC;
                  end else begin
                     mode_in = MODE_NORMAL;
                  end
               end
               MODE_CSI: begin
                  if (is_digit) begin
                     open_in = 1'b1;
                     if (!open_ff) begin
                        kept_in = count_ff < CNT_W'(MAX_PARAMS);
                        if (count_ff < CNT_W'(MAX_PARAMS)) count_in = count_ff + CNT_W'(1);
                     end
                     wr_addr = open_ff ? IDX_W'(count_ff - CNT_W'(1)) : count_ff[IDX_W-1:0];
                     wr_data = (prod > 20'd65535) ? 16'hffff : prod[15:0];
                     if (open_ff ? kept_ff : (count_ff < CNT_W'(MAX_PARAMS))) begin
                        wr_en  = 1'b1;
                        acc_in = wr_data;
                        if (wr_addr == IDX_W'(0)) p0_in = wr_data;
                        if (wr_addr == IDX_W'(1)) p1_in = wr_data;
                     end
                  end else if (byte_ff == CH_SEMI) begin
                     if (!open_ff && count_ff < CNT_W'(MAX_PARAMS)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        if (wr_addr == IDX_W'(0)) p0_in = '0;
                        if (wr_addr == IDX_W'(1)) p1_in = '0;
                     end
                     open_in = 1'b0;
                     kept_in = 1'b0;
                  end else if (byte_ff != CH_QUEST) begin
                     mode_in = MODE_NORMAL;
                     case (byte_ff)
                        CMD_CUP, CMD_HVP: begin
                           crow_in = (p0m1 > {10'd0, rows_m1}) ? rows_m1 : p0m1[ROW_W-1:0];
                           ccol_in = (p1m1 > {9'd0, cols_m1}) ? cols_m1 : p1m1[COL_W-1:0];
                        end
                        CMD_CUU: begin
                           crow_in = (step >= {10'd0, cr}) ? '0 : cr - step[ROW_W-1:0];
                        end
                        CMD_CUD: begin
                           crow_in = (row_sum > {11'd0, rows_m1}) ? rows_m1
                                     : row_sum[ROW_W-1:0];
                        end
                        CMD_CUF: begin
                           ccol_in = (col_sum > {10'd0, cols_m1}) ? cols_m1
                                     : col_sum[COL_W-1:0];
                        end
                        CMD_CUB: begin
                           ccol_in = (step >= {9'd0, cc}) ? '0 : cc - step[COL_W-1:0];
                        end
                        CMD_ED: begin
                           out_in = clear_res;
                           if (p0_ff == 16'd0) begin
                              status.has_result = 1'b1;
                           end else if (p0_ff == 16'd2) begin
                              out_in.row        = '0;
                              out_in.col        = '0;
                              status.has_result = 1'b1;
                           end
                        end
                        CMD_EL: begin
                           out_in         = clear_res;
                           out_in.end_row = cr;
                           if (p0_ff == 16'd0) begin
                              status.has_result = 1'b1;
                           end else if (p0_ff == 16'd1) begin
                              out_in.col        = '0;
                              out_in.end_col    = cc;
                              status.has_result = 1'b1;
                           end else if (p0_ff == 16'd2) begin
                              out_in.col        = '0;
                              status.has_result = 1'b1;
                           end
                        end
                        CMD_SGR: begin
                           if (count_ff == '0) begin
                              fg_in    = FG_RESET;
                              bg_in    = '0;
                              style_in = '0;
                           end else begin
                              status.sgr_start = 1'b1;
                              sgr_idx_in       = '0;
                           end
                        end
                        default: mode_in = MODE_NORMAL;
                     endcase
                  end
               end
               default: begin
                  if (byte_ff == CH_BEL || byte_ff == CH_ESC) mode_in = MODE_NORMAL;
               end
            endcase
         end
      end

      status.sgr_last   = sgr_idx_ff == IDX_W'(count_ff - CNT_W'(1));
      status.has_second = second_ff;

      if (cmd.sgr_apply) begin
         sgr_idx_in = sgr_idx_ff + IDX_W'(1);
         if (rd_data == 16'd0) begin
            fg_in    = FG_RESET;
            bg_in    = '0;
            style_in = '0;
         end else if (rd_data == 16'd1) style_in = style_ff | 3'b001;
         else if (rd_data == 16'd3)  style_in = style_ff | 3'b010;
         else if (rd_data == 16'd4)  style_in = style_ff | 3'b100;
         else if (rd_data == 16'd22) style_in = style_ff & 3'b110;
         else if (rd_data == 16'd23) style_in = style_ff & 3'b101;
         else if (rd_data == 16'd24) style_in = style_ff & 3'b011;
         else if (rd_data >= 16'd30 && rd_data <= 16'd37) fg_in = 4'(rd_data - 16'd30);
         else if (rd_data == 16'd39) fg_in = FG_RESET;
         else if (rd_data >= 16'd40 && rd_data <= 16'd47) bg_in = 4'(rd_data - 16'd40);
         else if (rd_data == 16'd49) bg_in = '0;
         else if (rd_data >= 16'd90 && rd_data <= 16'd97) fg_in = 4'(rd_data - 16'd82);
         else if (rd_data >= 16'd100 && rd_data <= 16'd107) bg_in = 4'(rd_data - 16'd92);
      end

      if (cmd.load_second) begin
         out_in    = scroll_res;
         second_in = 1'b0;
      end
   end

   assign result = out_ff;

endmodule

/* rtl/core/vt_escape_terminal_cursor_engine.sv */
// Terminal escape parser and cursor engine. Takes one byte per item and
// returns zero, one or two cell-write, scroll or clear-span results. A byte
// is taken, executed in the next cycle, and its results are offered one at
// a time. An SGR final walks its stored parameters (up to 16) through the
// parameter RAM, reading each one and then applying it. The block takes no
// new byte while results are waiting on the result channel.
// depends on vtc_pkg, vtc_ctrl and vtc_dp
module vt_escape_terminal_cursor_engine
   import vtc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // in_byte
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // op, row, col, end_row, end_col,
                                           // glyph, fg_color, bg_color, style, zero pad
   output logic               rsp_tlast,
   input  logic               csr_we,
   input  logic               csr_addr,
   input  logic [7:0]         csr_wdata
);

   cmd_type    cmd;
   status_type status;
   res_type    result;

   vtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   vtc_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_addr (csr_addr),
      .csr_wdata(csr_wdata),
      .req_byte (req_tdata),
      .cmd      (cmd),
      .status   (status),
      .result   (result)
   );

   assign rsp_tdata = {2'b00, result.style, result.bg_color, result.fg_color, result.glyph,
                       result.end_col, result.end_row, result.col, result.row, result.op};
   assign rsp_tlast = result.last;

endmodule
